// ===== hdl/assert_macros.svh =====
// Assertion helper macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define HBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form of the clocked assertion.
`define HBA_ASSERT_IMP(lbl, ante, cons, msg) \
  `HBA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== hdl/hba_pkg.sv =====
// Types, constants and helper functions of the hierarchical bitmap allocator.
package hba_pkg;

  localparam int unsigned LEVELS     = 3;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned ID_W       = DIGIT_W * LEVELS;
  localparam int unsigned MAXSEG_W   = 19;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CLR_W      = (LEVELS > 1) ? DIGIT_W * (LEVELS - 1) : 1;
  localparam int unsigned PADDR_W    = 3;
  localparam logic [MAXSEG_W-1:0] MAXSEG_RESET = MAXSEG_W'(262144);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DBL  = 2'd2;

  localparam logic [0:0] REG_MAXSEG = 1'b0;

  // Request travelling down the chain, one level per hop.
  typedef struct packed {
    logic            vld;
    logic            alloc;
    logic [ID_W-1:0] fid;
    logic [ID_W-1:0] row;
  } dn_tok_t;

  // Completion travelling back up the chain.
  typedef struct packed {
    logic                vld;
    logic                clr;
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] status;
  } up_tok_t;

  // Index of the lowest set bit, zero for an empty word.
  function automatic logic [DIGIT_W-1:0] lowest_set(input logic [63:0] w);
    logic [DIGIT_W-1:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (w[i]) r = DIGIT_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== hdl/hba_cell.sv =====
// One tree level: its mask memory, down-walk step and up-walk update.
module hba_cell #(
  parameter int unsigned LV = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clr_en_i,
  input  logic [hba_pkg::CLR_W-1:0]    clr_addr_i,
  input  logic [hba_pkg::MAXSEG_W-1:0] max_seg_i,
  input  hba_pkg::dn_tok_t       dn_i,
  output hba_pkg::dn_tok_t       dn_o,
  input  hba_pkg::up_tok_t       up_i,
  output hba_pkg::up_tok_t       up_o
);
  import hba_pkg::*;

  localparam int unsigned ADDR_W = (LV > 0) ? DIGIT_W * LV : 1;
  localparam int unsigned DEPTH  = 1 << (DIGIT_W * LV);
  localparam logic [ADDR_W-1:0] AMASK = ADDR_W'(DEPTH - 1);
  localparam bit LAST = (LV == LEVELS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_q;
  logic [1:0]  state_q, state_d;
  dn_tok_t     tok_q, tok_d;
  logic [63:0] word_q, word_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  dn_tok_t     dn_q, dn_d;
  up_tok_t     up_q, up_d;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [63:0]       wdata;
  logic [DIGIT_W-1:0] digit;
  logic [63:0]       bitm, cleared, held_clr;
  logic [ID_W-1:0]   new_row;

  // Step arithmetic on the word just read.
  always_comb begin
    digit    = tok_q.alloc ? lowest_set(rdata_q)
                           : tok_q.fid[ID_W-1-DIGIT_W*LV -: DIGIT_W];
    bitm     = 64'd1 << digit;
    cleared  = rdata_q & ~bitm;
    held_clr = word_q & ~(64'd1 << digit_q);
    new_row  = (tok_q.row << DIGIT_W) | ID_W'(digit);
  end

  // Sequence one level of the walk.
  always_comb begin
    state_d = state_q;
    tok_d   = tok_q;
    word_d  = word_q;
    digit_d = digit_q;
    dn_d    = '0;
    up_d    = '0;
    we      = 1'b0;
    waddr   = ADDR_W'(tok_q.row) & AMASK;
    wdata   = rdata_q;
    unique case (state_q)
      S_IDLE: begin
        if (dn_i.vld) begin
          tok_d   = dn_i;
          state_d = S_RD;
        end
      end
      S_RD: begin
        word_d  = rdata_q;
        digit_d = digit;
        state_d = S_IDLE;
        if (tok_q.alloc) begin
          if (rdata_q == '0) begin
            up_d = '{vld: 1'b1, clr: 1'b0, id: '0, status: ST_FULL};
          end else if (!LAST) begin
            dn_d     = tok_q;
            dn_d.row = new_row;
            state_d  = S_WAIT;
          end else if ({1'b0, new_row} >= max_seg_i) begin
            up_d = '{vld: 1'b1, clr: 1'b0, id: '0, status: ST_FULL};
          end else begin
            we    = 1'b1;
            wdata = cleared;
            up_d  = '{vld: 1'b1, clr: (cleared == '0), id: new_row, status: ST_OK};
          end
        end else begin
          we    = 1'b1;
          wdata = rdata_q | bitm;
          if (!LAST) begin
            dn_d     = tok_q;
            dn_d.row = new_row;
            state_d  = S_WAIT;
          end else begin
            up_d = '{vld: 1'b1, clr: 1'b0, id: '0,
                     status: rdata_q[digit] ? ST_DBL : ST_OK};
          end
        end
      end
      S_WAIT: begin
        if (up_i.vld) begin
          up_d    = up_i;
          up_d.clr = 1'b0;
          if (up_i.clr) begin
            we       = 1'b1;
            wdata    = held_clr;
            up_d.clr = (held_clr == '0);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // Reset sweep fills every word with ones.
    if (clr_en_i) begin
      we    = 1'b1;
      waddr = ADDR_W'(clr_addr_i) & AMASK;
      wdata = '1;
    end
  end

  // Mask memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (dn_i.vld) rdata_q <= mem[ADDR_W'(dn_i.row) & AMASK];
  end

  // Hold the walk state of this level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dn_q    <= '0;
      up_q    <= '0;
    end else begin
      state_q <= state_d;
      dn_q    <= dn_d;
      up_q    <= up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q   <= tok_d;
    word_q  <= word_d;
    digit_q <= digit_d;
  end

  assign dn_o = dn_q;
  assign up_o = up_q;

endmodule

// ===== hdl/hierarchical_bitmap_segment_allocator_top.sv =====
// Top level of the hierarchical bitmap segment allocator.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries command_i and free_id_i.
//   command 0 allocates the lowest free id below the segment limit, command 1
//   frees free_id_i. Output channel (out_valid_o / out_stall_i) returns one
//   transaction per command: segment_id_o and status_o (0 ok, 1 full,
//   2 double free).
//   The tree is a chain of one cell per level; a request walks down one
//   level through a registered memory read and a registered hand-off, and
//   the completion walks back up one level per cycle. An alloc that finds
//   the root empty answers from the root without walking further down.
//   One item is in flight at a time, so the next input is accepted only
//   once the last result has reached the output register.
//   After reset the block sweeps every mask word to all ones, one row per
//   cycle; in_stall_o stays high meanwhile and the APB port is usable at
//   once. The segment limit resets to 262144.
//   A finished result waits in the output register while the receiver
//   stalls; the next input is taken, and a second result is parked until
//   the first one leaves.
module hierarchical_bitmap_segment_allocator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic [17:0]                     free_id_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [17:0]                     segment_id_o,
  output logic [1:0]                      status_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hba_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import hba_pkg::*;

  logic [MAXSEG_W-1:0] max_seg_q;
  logic                clr_q;
  logic [CLR_W-1:0]    cnt_q;
  logic                busy_q, busy_d;
  logic                out_v_q, out_v_d;
  logic [ID_W-1:0]     out_id_q;
  logic [STATUS_W-1:0] out_st_q;
  logic                pend_v_q, pend_v_d;
  logic [ID_W-1:0]     pend_id_q;
  logic [STATUS_W-1:0] pend_st_q;

  dn_tok_t dn [LEVELS+1];
  up_tok_t up [LEVELS+1];
  logic    in_acc, out_free;

  assign pready     = 1'b1;
  assign in_stall_o = busy_q | clr_q;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_v_q | ~out_stall_i;

  // Register read back.
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_MAXSEG: prdata = 32'(max_seg_q);
      default:    prdata = '0;
    endcase
  end

  // Feed the head of the chain.
  assign dn[0] = '{vld: in_acc, alloc: (command_i == CMD_ALLOC), fid: free_id_i, row: '0};
  assign up[LEVELS] = '0;

  for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
    hba_cell #(.LV(g)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_en_i   (clr_q),
      .clr_addr_i (cnt_q),
      .max_seg_i  (max_seg_q),
      .dn_i       (dn[g]),
      .dn_o       (dn[g+1]),
      .up_i       (up[g+1]),
      .up_o       (up[g])
    );
  end

  // Track the busy flag, the output register and the parked result.
  always_comb begin
    busy_d   = busy_q | in_acc;
    out_v_d  = out_v_q & out_stall_i;
    pend_v_d = pend_v_q;
    if (up[0].vld) begin
      if (out_free) begin
        out_v_d = 1'b1;
        busy_d  = 1'b0;
      end else begin
        pend_v_d = 1'b1;
      end
    end else if (pend_v_q && out_free) begin
      out_v_d  = 1'b1;
      pend_v_d = 1'b0;
      busy_d   = 1'b0;
    end
  end

  // Configuration, reset sweep, busy flag and result buffering.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_seg_q <= MAXSEG_RESET;
      clr_q     <= 1'b1;
      cnt_q     <= '0;
      busy_q    <= 1'b0;
      out_v_q   <= 1'b0;
      pend_v_q  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_MAXSEG) begin
        max_seg_q <= pwdata[MAXSEG_W-1:0];
      end
      if (clr_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) clr_q <= 1'b0;
      end
      busy_q   <= busy_d;
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (up[0].vld) begin
      if (out_free) begin
        out_id_q <= up[0].id;
        out_st_q <= up[0].status;
      end else begin
        pend_id_q <= up[0].id;
        pend_st_q <= up[0].status;
      end
    end else if (pend_v_q && out_free) begin
      out_id_q <= pend_id_q;
      out_st_q <= pend_st_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign segment_id_o = out_id_q;
  assign status_o     = out_st_q;

  `include "assert_macros.svh"

  `HBA_ASSERT_IMP(a_pend_has_out, pend_v_q, out_v_q, "parked result without output")
  `HBA_ASSERT_IMP(a_no_in_during_clr, clr_q, !in_acc, "input taken during sweep")
  `HBA_ASSERT_IMP(a_done_only_busy, up[0].vld, busy_q && !pend_v_q, "stray completion")
  `HBA_ASSERT_IMP(a_acc_sets_busy, in_acc, ##1 busy_q, "busy not raised")

endmodule
